/* design/bstf_pkg.sv */
`default_nettype none
package bstf_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 1024;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  // Eviction limit, clamped so a checked insert never overflows the ring
  localparam int KEEP_LIMIT = 1023;
  localparam int LIMIT      = (KEEP_LIMIT < RING_DEPTH - 1) ? KEEP_LIMIT : RING_DEPTH - 1;

  // Key comparison: id words plus slot, split into pieces, one piece per cell
  localparam int PIECE_W = 64;
  localparam int N_CELLS = 5;
  localparam int KEY_W   = PIECE_W * N_CELLS;
  localparam int OWN_W   = 256;

  // Commands
  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key_id_w0;
    logic [63:0] key_id_w1;
    logic [63:0] key_id_w2;
    logic [63:0] key_id_w3;
    logic [31:0] key_slot;
    logic [63:0] owner_w0;
    logic [63:0] owner_w1;
    logic [63:0] owner_w2;
    logic [63:0] owner_w3;
    logic        update;
  } in_t;

  typedef struct packed {
    logic accepted;
    logic key_absent;
    logic inserted;
    logic evicted;
  } out_t;

  // Data handed from one compare cell to the next
  typedef struct packed {
    logic             vld;
    logic             match;
    logic [PTR_W-1:0] pos;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] ref_key;
  } cell_bus_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

/* design/bounded_seen_table_fifo_evict_top.sv */
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid_i/in_stall_o   | in_i  (in_t)
// out     | output    | out_valid_o/out_stall_i | out_o (out_t)
//
// One item at a time; the scan reads the stored entries, one ring entry per
// cycle, through the key memory port into a row of five compare cells.
// Reset empties the table at once; entry storage needs no clearing.
// A waiting result is held while out is stalled; the next item is taken
// once the current one has left the finish step.
module bounded_seen_table_fifo_evict_top import bstf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

  state_e           state_q, state_d;
  in_t              item_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0] issue_q, tail_cnt_q;
  logic             rd_vld_q;
  logic [PTR_W-1:0] rd_pos_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [OWN_W-1:0] owner_rd_q;
  logic             hit_q;
  logic [PTR_W-1:0] hit_pos_q;
  logic             res_ins_q, res_evict_q;
  out_t             out_q;
  logic             out_vld_q;

  logic [KEY_W-1:0] key_mem   [RING_DEPTH];
  logic [OWN_W-1:0] owner_mem [RING_DEPTH];

  logic             in_xfer, out_xfer, fin_load, scan_rd, scan_done;
  logic [PTR_W-1:0] scan_addr;
  logic [KEY_W-1:0] ref_key;
  logic [OWN_W-1:0] ref_owner;
  cell_bus_t        head, tail;

  logic             ins;
  logic [CNT_W-1:0] drop_n, base_cnt;
  logic [PTR_W-1:0] base_old, wr_pos;
  logic             key_we, own_we;
  logic [PTR_W-1:0] own_pos;
  logic             accepted;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_vld_q & ~out_stall_i;

  assign ref_key   = {{(KEY_W-288){1'b0}}, item_q.key_slot, item_q.key_id_w3,
                      item_q.key_id_w2, item_q.key_id_w1, item_q.key_id_w0};
  assign ref_owner = {item_q.owner_w3, item_q.owner_w2, item_q.owner_w1, item_q.owner_w0};

  assign scan_addr = oldest_q + issue_q[PTR_W-1:0];
  assign scan_rd   = (state_q == ST_SCAN) && (issue_q < cnt_q);
  assign scan_done = (tail_cnt_q == cnt_q);

  // Work out eviction and insert position
  always_comb begin
    ins = ~hit_q & (((item_q.cmd == CMD_CHECK) & item_q.update) | (item_q.cmd == CMD_INSERT));
    drop_n = '0;
    if (item_q.cmd == CMD_CHECK) begin
      if (cnt_q > CNT_W'(LIMIT)) drop_n = cnt_q - CNT_W'(LIMIT);
    end else if (cnt_q == CNT_W'(RING_DEPTH)) begin
      drop_n = CNT_W'(1);
    end
    base_cnt = cnt_q - drop_n;
    base_old = oldest_q + drop_n[PTR_W-1:0];
    wr_pos   = base_old + base_cnt[PTR_W-1:0];
    own_pos  = hit_q ? hit_pos_q : wr_pos;
  end

  assign accepted = ((item_q.cmd == CMD_CHECK) && hit_q) ? (owner_rd_q == ref_owner) : 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_UPD;
      ST_UPD:  state_d = ST_FIN;
      ST_FIN:  if (!out_vld_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    key_we     = 1'b0;
    own_we     = 1'b0;
    fin_load   = 1'b0;
    cnt_d      = cnt_q;
    oldest_d   = oldest_q;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SCAN: ;
      ST_UPD: begin
        key_we = ins;
        own_we = ins | ((item_q.cmd == CMD_INSERT) & hit_q);
        if (ins) begin
          cnt_d    = base_cnt + CNT_W'(1);
          oldest_d = base_old;
        end
      end
      ST_FIN:  fin_load = ~out_vld_q | ~out_stall_i;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      oldest_q   <= '0;
      issue_q    <= '0;
      tail_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      oldest_q <= oldest_d;
      rd_vld_q <= scan_rd;
      if (in_xfer) begin
        issue_q    <= '0;
        tail_cnt_q <= '0;
        hit_q      <= 1'b0;
      end else begin
        if (scan_rd) issue_q <= issue_q + CNT_W'(1);
        if (tail.vld) begin
          tail_cnt_q <= tail_cnt_q + CNT_W'(1);
          if (tail.match) hit_q <= 1'b1;
        end
      end
      if (fin_load) out_vld_q <= 1'b1;
      else if (out_xfer) out_vld_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) item_q <= in_i;
    rd_pos_q <= scan_addr;
    if (tail.vld && tail.match && !hit_q) hit_pos_q <= tail.pos;
    if (state_q == ST_UPD) begin
      res_ins_q   <= ins;
      res_evict_q <= ins & (drop_n != '0);
    end
    if (fin_load) begin
      out_q.accepted   <= accepted;
      out_q.key_absent <= ~hit_q;
      out_q.inserted   <= res_ins_q;
      out_q.evicted    <= res_evict_q;
    end
  end

  // Key ring storage
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_pos] <= ref_key;
    key_rd_q <= key_mem[scan_addr];
  end

  // Owner ring storage
  always_ff @(posedge clk_i) begin
    if (own_we) owner_mem[own_pos] <= ref_owner;
    owner_rd_q <= owner_mem[hit_pos_q];
  end

  // Feed the compare row
  always_comb begin
    head.vld     = rd_vld_q;
    head.match   = 1'b1;
    head.pos     = rd_pos_q;
    head.key     = key_rd_q;
    head.ref_key = ref_key;
  end

  bstf_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .tail_o (tail)
  );

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

/* design/bstf_cell.sv */
`default_nettype none
module bstf_cell import bstf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_bus_t bus_i,
  output cell_bus_t      bus_o
);

  logic      vld_q;
  cell_bus_t pay_q;

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= bus_i.vld;
    end
  end

  // Compare the low piece, then shift the next piece into place
  always_ff @(posedge clk_i) begin
    pay_q.vld     <= 1'b0;
    pay_q.match   <= bus_i.match & (bus_i.key[PIECE_W-1:0] == bus_i.ref_key[PIECE_W-1:0]);
    pay_q.pos     <= bus_i.pos;
    pay_q.key     <= bus_i.key >> PIECE_W;
    pay_q.ref_key <= bus_i.ref_key >> PIECE_W;
  end

  always_comb begin
    bus_o     = pay_q;
    bus_o.vld = vld_q;
  end

endmodule
`default_nettype wire

/* design/bstf_chain.sv */
`default_nettype none
module bstf_chain import bstf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_bus_t head_i,
  output cell_bus_t      tail_o
);

  cell_bus_t bus [N_CELLS+1];

  assign bus[0] = head_i;

  // Row of compare cells, one key piece each
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    bstf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .bus_i  (bus[g]),
      .bus_o  (bus[g+1])
    );
  end

  assign tail_o = bus[N_CELLS];

endmodule
`default_nettype wire
